[rtl/core/nap_pkg.sv]
// Shared types, codes and sizes for the numeric argument parser.
package nap_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int DEF_WIDTH   = 31;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // digit value of a character; NOT_DIGIT for anything else
    localparam logic [4:0] NOT_DIGIT = 5'd16;
    localparam logic [4:0] LIM_OCT   = 5'd8;
    localparam logic [4:0] LIM_DEC   = 5'd10;
    localparam logic [4:0] LIM_HEX   = 5'd16;

    typedef enum logic [1:0] {
        ST_NUMBER  = 2'd0,
        ST_DEFAULT = 2'd1,
        ST_NAN     = 2'd2,
        ST_END     = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_DEFAULT_ENABLE = 1'b0,
        CFG_DEFAULT_NUMBER = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] number_value;
        logic [1:0]           parse_status;
        logic [7:0]           terminator_char;
        logic                 terminator_is_end;
    } t_out_item;

    // classified character as held in the queue
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
        logic       is_blank;
        logic       is_newline;
        logic       is_x;
        logic [4:0] digit;
    } t_cls;

    typedef struct packed {
        logic                 default_enable;
        logic [DEF_WIDTH-1:0] default_number;
    } t_cfg;

endpackage

[rtl/core/nap_front.sv]
// Front end: takes input items and classifies each character.
module nap_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nap_pkg::t_in_item i_in_item,
    output logic              o_push,
    output nap_pkg::t_cls     o_cls,
    input  logic              i_q_full
);
    import nap_pkg::*;

    logic [7:0] w_c;
    logic [4:0] w_digit;

    assign w_c = i_in_item.char_code;

    always_comb begin
        if (w_c inside {[CH_ZERO:CH_NINE]}) begin
            w_digit = 5'(w_c - CH_ZERO);
        end else if (w_c inside {[CH_UC_A:CH_UC_F]}) begin
            w_digit = 5'(w_c - CH_UC_A) + LIM_DEC;
        end else if (w_c inside {[CH_LC_A:CH_LC_F]}) begin
            w_digit = 5'(w_c - CH_LC_A) + LIM_DEC;
        end else begin
            w_digit = NOT_DIGIT;
        end
    end

    always_comb begin
        o_cls.char_code  = w_c;
        o_cls.is_end     = i_in_item.end_of_input || (w_c == CH_NUL);
        o_cls.is_blank   = w_c inside {CH_SPACE, CH_TAB};
        o_cls.is_newline = (w_c == CH_NL);
        o_cls.is_x       = w_c inside {CH_LC_X, CH_UC_X};
        o_cls.digit      = w_digit;
    end

    // stall is held off reset so nothing is taken before the queue is cleared
    logic r_live;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign o_in_stall = i_q_full || !r_live;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

[rtl/core/nap_queue.sv]
// Short register queue between the front and the back end.
module nap_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nap_pkg::t_cls i_cls,
    output logic          o_full,
    output logic          o_valid,
    output nap_pkg::t_cls o_cls,
    input  logic          i_pop
);
    import nap_pkg::*;

    t_cls               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cls;
        end
    end

endmodule

[rtl/core/nap_back.sv]
// Back end: parse state machine, accumulator and registered result.
module nap_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nap_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  nap_pkg::t_cls      i_q_cls,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nap_pkg::t_out_item o_out_item
);
    import nap_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ZERO = 5'b00010,
        PH_DEC  = 5'b00100,
        PH_OCT  = 5'b01000,
        PH_HEX  = 5'b10000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   w_res_valid;
    t_out_item              w_res;
    logic                   w_out_free;
    logic [4:0]             w_lim;
    logic [VALUE_WIDTH-1:0] w_scaled;
    logic [VALUE_WIDTH-1:0] w_dig;
    logic                   w_number;

    assign w_dig = VALUE_WIDTH'(i_q_cls.digit[3:0]);

    // base limit and acc * base for the number phases
    always_comb begin
        case (r_phase)
            PH_DEC: begin
                w_lim    = LIM_DEC;
                w_scaled = (r_acc << 3) + (r_acc << 1);
            end
            PH_HEX: begin
                w_lim    = LIM_HEX;
                w_scaled = r_acc << 4;
            end
            default: begin
                w_lim    = LIM_OCT;
                w_scaled = r_acc << 3;
            end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        w_res_valid = 1'b0;
        w_res       = '0;
        w_number    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_q_cls.is_end) begin
                    w_res_valid             = 1'b1;
                    w_res.parse_status      = ST_END;
                    w_res.terminator_is_end = 1'b1;
                end else if (i_q_cls.is_blank) begin
                    n_phase = PH_IDLE;
                end else if (i_q_cls.is_newline) begin
                    if (i_cfg.default_enable) begin
                        w_res_valid           = 1'b1;
                        w_res.number_value    = OUT_WIDTH'(i_cfg.default_number);
                        w_res.parse_status    = ST_DEFAULT;
                        w_res.terminator_char = i_q_cls.char_code;
                    end
                end else if (i_q_cls.digit == 5'd0) begin
                    n_phase = PH_ZERO;
                    n_acc   = '0;
                end else if (i_q_cls.digit < LIM_DEC) begin
                    n_phase = PH_DEC;
                    n_acc   = w_dig;
                end else begin
                    w_res_valid           = 1'b1;
                    w_res.parse_status    = ST_NAN;
                    w_res.terminator_char = i_q_cls.char_code;
                end
            end
            PH_ZERO: begin
                if (i_q_cls.is_end) begin
                    w_number = 1'b1;
                end else if (i_q_cls.is_x) begin
                    n_phase = PH_HEX;
                    n_acc   = '0;
                end else begin
                    n_phase  = PH_OCT;
                    w_number = 1'b1;
                end
            end
            PH_DEC, PH_OCT, PH_HEX: begin
                w_number = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
                n_acc   = '0;
            end
        endcase

        // digit of the current base, or end of the number
        if (w_number) begin
            if (i_q_cls.is_end) begin
                w_res_valid             = 1'b1;
                w_res.number_value      = OUT_WIDTH'(r_acc);
                w_res.parse_status      = ST_NUMBER;
                w_res.terminator_is_end = 1'b1;
            end else if (i_q_cls.digit >= w_lim) begin
                w_res_valid           = 1'b1;
                w_res.number_value    = OUT_WIDTH'(r_acc);
                w_res.parse_status    = ST_NUMBER;
                w_res.terminator_char = i_q_cls.char_code;
            end else begin
                n_acc = w_scaled + w_dig;
            end
        end

        if (w_res_valid) begin
            n_phase = PH_IDLE;
            n_acc   = '0;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = i_q_valid && (!w_res_valid || w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
            end
            if (w_out_free) begin
                r_out_valid <= o_pop && w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && o_pop && w_res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[rtl/core/numeric_argument_parser.sv]
// Numeric argument parser top level: configuration registers, front, queue and back end.
// Takes one character per clock while input is not stalled and returns at most one result per
// character: a decimal, octal (leading 0) or hex (0x) number, the default on a newline when
// enabled, not-a-number, or end of input. Sustained rate is one item per clock while the output
// is not stalled. A character enters the two-entry queue when accepted and passes through the
// back end state machine into the registered output. The queue lets input keep flowing while a
// result waits; input stalls only when the queue is full, and during reset until the front
// end's live register is set.
// Configuration writes are always ready; write them only while the block is idle.
module numeric_argument_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  nap_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output nap_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [nap_pkg::DEF_WIDTH-1:0] i_cfg_data
);
    import nap_pkg::*;

    t_cfg r_cfg;
    logic w_push, w_full, w_q_valid, w_pop;
    t_cls w_cls_in, w_cls_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEFAULT_ENABLE: r_cfg.default_enable <= i_cfg_data[0];
                CFG_DEFAULT_NUMBER: r_cfg.default_number <= i_cfg_data;
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    nap_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_push     (w_push),
        .o_cls      (w_cls_in),
        .i_q_full   (w_full)
    );

    nap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_cls_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cls   (w_cls_out),
        .i_pop   (w_pop)
    );

    nap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_cls     (w_cls_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/core/nap_checker.sv]
// Port-level checks for the numeric argument parser, bound to the top level.
module nap_port_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  nap_pkg::t_out_item o_out_item
);
    import nap_pkg::*;

    // a result held back by stall keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.parse_status == ST_END |->
            o_out_item.number_value == '0 && o_out_item.terminator_char == CH_NUL &&
            o_out_item.terminator_is_end)
        else $error("end-of-input item malformed");

    // default only from a newline, never wider than the register
    a_default_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.parse_status == ST_DEFAULT |->
            o_out_item.terminator_char == CH_NL && !o_out_item.terminator_is_end &&
            !o_out_item.number_value[OUT_WIDTH-1])
        else $error("default item malformed");

    a_nan_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.parse_status == ST_NAN |->
            o_out_item.number_value == '0 && !o_out_item.terminator_is_end &&
            o_out_item.terminator_char != CH_NUL)
        else $error("not-a-number item malformed");

endmodule

bind numeric_argument_parser nap_port_checker u_nap_checker (.*);
